[rtl/assert_macros.svh]
// Assertion helpers included by the motion predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/fpmp_pkg.sv]
package fpmp_pkg;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [2:0] REG_GAIN    = 3'd0;
	localparam logic [2:0] REG_HOLD    = 3'd1;
	localparam logic [2:0] REG_VSCALE  = 3'd2;
	localparam logic [2:0] REG_JUMP    = 3'd3;
	localparam logic [2:0] REG_SCALE_X = 3'd4;
	localparam logic [2:0] REG_SCALE_Y = 3'd5;

	localparam logic [16:0] GAIN_ONE        = 17'd65536;
	localparam logic [16:0] GAIN_RESET      = 17'd7000;
	localparam logic [15:0] HOLD_RESET      = 16'd2621;
	localparam logic [7:0]  VSCALE_RESET    = 8'd25;
	localparam logic [7:0]  JUMP_RESET      = 8'd2;
	localparam logic [23:0] SCALE_X_RESET   = 24'd1482910;
	localparam logic [23:0] SCALE_Y_RESET   = 24'd741455;

	typedef enum logic [3:0] {
		S_IDLE,
		S_JUMP,
		S_MOVE,
		S_VX,
		S_VY,
		S_SX,
		S_SY,
		S_BX,
		S_BY,
		S_UPD,
		S_DIFF,
		S_OX,
		S_OY,
		S_FIN,
		S_DONE
	} fpmp_state_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} fpmp_mul_op_t;

endpackage

[rtl/fpmp_mult.sv]
module fpmp_mult
	import fpmp_pkg::*;
(
	input  logic                       clk,
	input  fpmp_mul_op_t               op,
	output logic signed [MUL_P_W-1:0]  prod_q
);

	// The product is registered so that the consumer sees it in the cycle after issue.
	always_ff @(posedge clk) begin
		prod_q <= op.a * op.b;
	end

endmodule

[rtl/fixed_point_motion_predictor.sv]
// Fixed-point dead-reckoning motion predictor.
// Input channel: sample_x, sample_y and elapsed, transferred when in_valid is high
// and in_stall is low. The block raises in_stall while it works on an item.
// Output channel: offset_x, offset_y, predicted_x and predicted_y, transferred when
// out_valid is high and out_stall is low. One result follows every input transfer.
// All products go through a single registered 34 by 32 bit multiplier, which
// a sequencer issues eight times per item.
// If the receiver stalls, the finished result waits in the output register and the
// sequencer holds in its last step until the register frees, so no further input
// is taken meanwhile.
// Configuration is written by the user through cfg_write, cfg_index and cfg_data,
// only while idle (the block does not enforce it); unknown indexes are ignored
// and gain values above one are clipped to one. Reset (arst_n low) clears all
// tracking state to zero and loads the default configuration.
`include "assert_macros.svh"

module fixed_point_motion_predictor
	import fpmp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sample_y,
	input  logic signed [31:0] elapsed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] offset_x,
	output logic signed [15:0] offset_y,
	output logic signed [31:0] predicted_x,
	output logic signed [31:0] predicted_y,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	fpmp_state_t state_q, state_d;

	logic [16:0] gain_q;
	logic [15:0] hold_limit_q;
	logic [7:0]  vscale_q;
	logic [7:0]  jump_limit_q;
	logic [23:0] scale_x_q;
	logic [23:0] scale_y_q;

	logic signed [31:0] last_x_q, last_y_q, pred_x_q, pred_y_q;
	logic signed [31:0] corr_x_q, corr_y_q, vel_x_q, vel_y_q, timer_q;
	logic               move_q, adv_q;

	logic signed [31:0] sx_q, sy_q, dt_q, dx_q, dy_q, step_x_q, step_y_q;
	logic signed [33:0] diff_q, sum_q;
	logic signed [15:0] offx_q, offy_q;

	logic signed [15:0] offset_x_q, offset_y_q;
	logic signed [31:0] predicted_x_q, predicted_y_q;
	logic               out_valid_q;

	fpmp_mul_op_t              mul_op;
	logic signed [MUL_P_W-1:0] prod;

	logic               accept, load_out;
	logic               jump, move, timer_ge;
	logic signed [32:0] timer_sum;
	logic signed [31:0] timer_sat;
	logic signed [31:0] dx, dy;
	logic signed [32:0] mid_x, mid_y;
	logic signed [32:0] u, w;
	logic signed [33:0] cdiff_x, cdiff_y;

	function automatic logic exceeds(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic [7:0] limit);
		logic signed [16:0] d;
		logic [16:0]        m;
		d = {a[15], a} - {b[15], b};
		m = d[16] ? 17'(-d) : 17'(d);
		return m > {9'd0, limit};
	endfunction

	function automatic logic signed [15:0] round_sat(input logic signed [59:0] p);
		logic signed [60:0] v;
		logic signed [28:0] q;
		v = {p[59], p} + 61'sd2147483648;
		q = v[60:32];
		if (v[60] && (v[31:0] != 32'd0)) begin
			q = q + 29'sd1;
		end
		if (q > 29'sd32767) begin
			return 16'sh7fff;
		end else if (q < -29'sd32768) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	fpmp_mult u_mult (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod)
	);

	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign jump = exceeds(sx_q[31:16], last_x_q[31:16], jump_limit_q)
		|| exceeds(sy_q[31:16], last_y_q[31:16], jump_limit_q)
		|| exceeds(sx_q[31:16], pred_x_q[31:16], jump_limit_q)
		|| exceeds(sy_q[31:16], pred_y_q[31:16], jump_limit_q);

	assign timer_sum = {timer_q[31], timer_q} + {dt_q[31], dt_q};
	assign timer_sat = (timer_sum[32] != timer_sum[31])
		? (timer_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : timer_sum[31:0];
	assign timer_ge  = !timer_q[31] && (timer_q[30:0] >= {15'd0, hold_limit_q});

	assign dx    = sx_q - last_x_q;
	assign dy    = sy_q - last_y_q;
	assign move  = (dx != 32'sd0) || (dy != 32'sd0) || timer_ge;
	assign mid_x = {sx_q[31], sx_q} + {last_x_q[31], last_x_q};
	assign mid_y = {sy_q[31], sy_q} + {last_y_q[31], last_y_q};

	assign cdiff_x = {{2{corr_x_q[31]}}, corr_x_q} - {{2{pred_x_q[31]}}, pred_x_q};
	assign cdiff_y = {{2{corr_y_q[31]}}, corr_y_q} - {{2{pred_y_q[31]}}, pred_y_q};
	assign u       = {pred_x_q[31], pred_x_q} - {last_x_q[31], last_x_q};
	assign w       = {pred_y_q[31], pred_y_q} - {last_y_q[31], last_y_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_JUMP;
			end
			S_JUMP: state_d = S_MOVE;
			S_MOVE: state_d = S_VX;
			S_VX:   state_d = S_VY;
			S_VY:   state_d = S_SX;
			S_SX:   state_d = S_SY;
			S_SY:   state_d = S_BX;
			S_BX:   state_d = S_BY;
			S_BY:   state_d = S_UPD;
			S_UPD:  state_d = S_DIFF;
			S_DIFF: state_d = S_OX;
			S_OX:   state_d = S_OY;
			S_OY:   state_d = S_FIN;
			S_FIN:  state_d = S_DONE;
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		mul_op.a = '0;
		mul_op.b = '0;
		unique case (state_q)
			S_VX: begin
				mul_op.a = {{2{dx_q[31]}}, dx_q};
				mul_op.b = {24'd0, vscale_q};
			end
			S_VY: begin
				mul_op.a = {{2{dy_q[31]}}, dy_q};
				mul_op.b = {24'd0, vscale_q};
			end
			S_SX: begin
				mul_op.a = {{2{dt_q[31]}}, dt_q};
				mul_op.b = vel_x_q;
			end
			S_SY: begin
				mul_op.a = {{2{dt_q[31]}}, dt_q};
				mul_op.b = vel_y_q;
			end
			S_BX: begin
				mul_op.a = cdiff_x;
				mul_op.b = {15'd0, gain_q};
			end
			S_BY: begin
				mul_op.a = cdiff_y;
				mul_op.b = {15'd0, gain_q};
			end
			S_OX: begin
				mul_op.a = diff_q;
				mul_op.b = {8'd0, scale_x_q};
			end
			S_OY: begin
				mul_op.a = sum_q;
				mul_op.b = {8'd0, scale_y_q};
			end
			default: begin
				mul_op.a = '0;
				mul_op.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= GAIN_RESET;
			hold_limit_q <= HOLD_RESET;
			vscale_q     <= VSCALE_RESET;
			jump_limit_q <= JUMP_RESET;
			scale_x_q    <= SCALE_X_RESET;
			scale_y_q    <= SCALE_Y_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GAIN:    gain_q <= (cfg_data[16:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[16:0];
				REG_HOLD:    hold_limit_q <= cfg_data[15:0];
				REG_VSCALE:  vscale_q <= cfg_data[7:0];
				REG_JUMP:    jump_limit_q <= cfg_data[7:0];
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			pred_x_q <= '0;
			pred_y_q <= '0;
			corr_x_q <= '0;
			corr_y_q <= '0;
			vel_x_q  <= '0;
			vel_y_q  <= '0;
			timer_q  <= '0;
			move_q   <= 1'b0;
			adv_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_JUMP: begin
					if (jump) begin
						last_x_q <= sx_q;
						last_y_q <= sy_q;
						pred_x_q <= sx_q;
						pred_y_q <= sy_q;
						corr_x_q <= sx_q;
						corr_y_q <= sy_q;
						vel_x_q  <= '0;
						vel_y_q  <= '0;
					end
					timer_q <= timer_sat;
				end
				S_MOVE: begin
					move_q <= move;
					if (move) begin
						corr_x_q <= mid_x[32:1];
						corr_y_q <= mid_y[32:1];
						last_x_q <= sx_q;
						last_y_q <= sy_q;
						timer_q  <= '0;
					end
				end
				S_VY: begin
					if (move_q) vel_x_q <= prod[31:0];
				end
				S_SX: begin
					if (move_q) vel_y_q <= prod[31:0];
				end
				S_SY: begin
					adv_q <= ((vel_x_q != 32'sd0) || (vel_y_q != 32'sd0)) && !timer_ge;
				end
				S_BY: begin
					if (adv_q) begin
						pred_x_q <= pred_x_q + prod[47:16] + step_x_q;
						corr_x_q <= corr_x_q + step_x_q;
					end
				end
				S_UPD: begin
					if (adv_q) begin
						pred_y_q <= pred_y_q + prod[47:16] + step_y_q;
						corr_y_q <= corr_y_q + step_y_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= sample_x;
			sy_q <= sample_y;
			dt_q <= elapsed;
		end
		if (state_q == S_MOVE) begin
			dx_q <= dx;
			dy_q <= dy;
		end
		if (state_q == S_SY) step_x_q <= prod[47:16];
		if (state_q == S_BX) step_y_q <= prod[47:16];
		if (state_q == S_DIFF) begin
			diff_q <= {u[32], u} - {w[32], w};
			sum_q  <= {u[32], u} + {w[32], w};
		end
		if (state_q == S_OY) offx_q <= round_sat(prod[59:0]);
		if (state_q == S_FIN) offy_q <= round_sat(prod[59:0]);
		if (load_out) begin
			offset_x_q    <= offx_q;
			offset_y_q    <= offy_q;
			predicted_x_q <= pred_x_q;
			predicted_y_q <= pred_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign offset_x    = offset_x_q;
	assign offset_y    = offset_y_q;
	assign predicted_x = predicted_x_q;
	assign predicted_y = predicted_y_q;

	`ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == S_JUMP, "transfer did not start work")
	`ASSERT_NEXT(a_jump_clears_vel, clk, arst_n, (state_q == S_JUMP) && jump, (vel_x_q == 32'sd0) && (vel_y_q == 32'sd0), "velocity not cleared on jump")
	`ASSERT_NEXT(a_move_clears_timer, clk, arst_n, (state_q == S_MOVE) && move, timer_q == 32'sd0, "hold timer not cleared on move")
	`ASSERT_NEXT(a_done_holds, clk, arst_n, (state_q == S_DONE) && out_valid_q && out_stall, state_q == S_DONE, "result overwrote a stalled transfer")
	`ASSERT_ALWAYS(a_gain_bound, clk, arst_n, gain_q <= GAIN_ONE, "gain above one")

endmodule

[sim/fixed_point_motion_predictor_tb.sv]
`timescale 1ns / 1ps

module fixed_point_motion_predictor_tb;
	import fpmp_pkg::*;

	localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 55;
	localparam int PAUSE_POINT = 27;
	localparam longint HALF_PIXEL = 64'sh0000_0000_8000_0000;
	localparam longint TIMER_MAX = 64'sd2147483647;
	localparam longint TIMER_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} motion_result_t;

	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] dt;
		bit                 typed;
		motion_result_t     want;
	} motion_row_t;

	localparam motion_result_t ZERO_RESULT = '0;
	localparam int DIRECTED_ROWS = 22;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] sample_x = '0;
	logic signed [31:0] sample_y = '0;
	logic signed [31:0] elapsed = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic signed [31:0] predicted_x;
	logic signed [31:0] predicted_y;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;

	fixed_point_motion_predictor DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.elapsed     (elapsed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.predicted_x (predicted_x),
		.predicted_y (predicted_y),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	// Tracker state and settings as the block should hold them.
	longint seen_x = 0, seen_y = 0, est_x = 0, est_y = 0, fix_x = 0, fix_y = 0;
	longint rate_x = 0, rate_y = 0, still_time = 0;
	longint gain_q16 = longint'(GAIN_RESET);
	longint hold_q16 = longint'(HOLD_RESET);
	longint vel_mult = longint'(VSCALE_RESET);
	longint jump_tiles = longint'(JUMP_RESET);
	longint iso_scale_x = longint'(SCALE_X_RESET);
	longint iso_scale_y = longint'(SCALE_Y_RESET);

	motion_result_t expected_motion [$];
	int fault_count = 0;
	int cycle_count = 0;
	int sender_gap_pct = 0;
	int recv_stall_pct = 0;
	int gap_by_mode [4] = '{0, 83, 0, 9};
	int stall_by_mode [4] = '{0, 0, 83, 9};

	motion_row_t motion_table [DIRECTED_ROWS] = '{
		'{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1, ZERO_RESULT},
		'{32'sh0010_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1,
			'{16'sd0, 16'sd0, 32'sh0010_0000, 32'sh0000_0000}},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1'b1,
			'{16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000}},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1,
			'{16'sd0, 16'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000}},
		'{32'sh7FFF_8000, 32'sh8000_0000, 32'sh0000_0400, 1'b0, ZERO_RESULT},
		'{32'sh7FFF_8000, 32'sh8000_0000, 32'sh0000_0400, 1'b0, ZERO_RESULT},
		'{32'sh7FFF_FFFF, 32'sh8000_8000, 32'sh0000_0400, 1'b0, ZERO_RESULT},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 1'b0, ZERO_RESULT},
		'{32'sh8001_0000, 32'sh7FFF_0000, 32'sh0000_0200, 1'b0, ZERO_RESULT},
		'{32'sh8001_0000, 32'sh7FFF_0000, 32'sh8000_0000, 1'b0, ZERO_RESULT},
		'{32'sh8001_0000, 32'sh7FFF_0000, 32'sh8000_0000, 1'b0, ZERO_RESULT},
		'{32'sh8001_0000, 32'sh7FFF_0000, 32'sh7FFF_FFFF, 1'b0, ZERO_RESULT},
		'{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'sh0001_0000, 1'b0, ZERO_RESULT},
		'{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0100, 1'b0, ZERO_RESULT},
		'{32'sh0001_8000, 32'shFFFF_0000, 32'sh0000_0100, 1'b0, ZERO_RESULT},
		'{32'sh0001_8000, 32'shFFFF_0000, 32'sh0000_0100, 1'b0, ZERO_RESULT},
		'{32'sh0001_8000, 32'shFFFF_0000, 32'sh0000_0100, 1'b0, ZERO_RESULT},
		'{32'sh0001_8000, 32'shFFFF_0000, 32'sh0000_0A3D, 1'b0, ZERO_RESULT},
		'{32'sh0002_0000, 32'sh0000_0000, 32'shFFFF_FF00, 1'b0, ZERO_RESULT},
		'{32'sh0002_0000, 32'sh0000_0000, 32'shFFFF_FF00, 1'b0, ZERO_RESULT},
		'{32'sh0002_8000, 32'sh0000_8000, 32'sh7FFF_FFFF, 1'b0, ZERO_RESULT},
		'{32'sh0002_8000, 32'sh0000_8000, 32'sh7FFF_0000, 1'b0, ZERO_RESULT}
	};

	function automatic longint wrap32(input longint v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic longint tile_gap(input longint ax, ay, bx, by);
		longint gx, gy;
		gx = (ax >>> 16) - (bx >>> 16);
		gy = (ay >>> 16) - (by >>> 16);
		if (gx < 0) gx = -gx;
		if (gy < 0) gy = -gy;
		return (gx > gy) ? gx : gy;
	endfunction

	function automatic longint blend_toward(input longint p, c);
		return wrap32((p * (64'sd65536 - gain_q16) + c * gain_q16) >>> 16);
	endfunction

	function automatic logic signed [15:0] round_pixels(input longint v);
		longint q;
		q = (v < 0) ? -((-v) >>> 32) : (v >>> 32);
		if (q > 32767) return 16'sh7FFF;
		if (q < -32768) return 16'sh8000;
		return q[15:0];
	endfunction

	function automatic motion_result_t advance_tracker(input logic signed [31:0] sx_in,
			input logic signed [31:0] sy_in, input logic signed [31:0] dt_in);
		longint sx, sy, dt, dx, dy, t, stx, sty, u, w;
		motion_result_t r;
		sx = longint'(sx_in);
		sy = longint'(sy_in);
		dt = longint'(dt_in);
		if (tile_gap(sx, sy, seen_x, seen_y) > jump_tiles ||
				tile_gap(sx, sy, est_x, est_y) > jump_tiles) begin
			seen_x = sx;
			est_x = sx;
			fix_x = sx;
			seen_y = sy;
			est_y = sy;
			fix_y = sy;
			rate_x = 0;
			rate_y = 0;
		end
		dx = wrap32(sx - seen_x);
		dy = wrap32(sy - seen_y);
		t = still_time + dt;
		if (t > TIMER_MAX) t = TIMER_MAX;
		if (t < TIMER_MIN) t = TIMER_MIN;
		still_time = t;
		if (dx != 0 || dy != 0 || still_time >= hold_q16) begin
			fix_x = (sx + seen_x) >>> 1;
			fix_y = (sy + seen_y) >>> 1;
			rate_x = wrap32(vel_mult * dx);
			rate_y = wrap32(vel_mult * dy);
			seen_x = sx;
			seen_y = sy;
			still_time = 0;
		end
		if ((rate_x != 0 || rate_y != 0) && still_time < hold_q16) begin
			stx = wrap32((dt * rate_x) >>> 16);
			sty = wrap32((dt * rate_y) >>> 16);
			est_x = wrap32(blend_toward(est_x, fix_x) + stx);
			est_y = wrap32(blend_toward(est_y, fix_y) + sty);
			fix_x = wrap32(fix_x + stx);
			fix_y = wrap32(fix_y + sty);
		end
		u = est_x - seen_x;
		w = est_y - seen_y;
		r.off_x = round_pixels(iso_scale_x * (u - w) + HALF_PIXEL);
		r.off_y = round_pixels(iso_scale_y * (u + w) + HALF_PIXEL);
		r.pos_x = est_x[31:0];
		r.pos_y = est_y[31:0];
		return r;
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic write_setting(input logic [2:0] idx, input logic [23:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_GAIN: begin
				gain_q16 = longint'(data[16:0]);
				if (gain_q16 > longint'(GAIN_ONE)) gain_q16 = longint'(GAIN_ONE);
			end
			REG_HOLD:    hold_q16 = longint'(data[15:0]);
			REG_VSCALE:  vel_mult = longint'(data[7:0]);
			REG_JUMP:    jump_tiles = longint'(data[7:0]);
			REG_SCALE_X: iso_scale_x = longint'(data);
			REG_SCALE_Y: iso_scale_y = longint'(data);
			default: ;
		endcase
	endtask

	task automatic program_block(input logic [23:0] gain, hold, vscale, jump, scx, scy);
		write_setting(REG_GAIN, gain);
		write_setting(REG_HOLD, hold);
		write_setting(REG_VSCALE, vscale);
		write_setting(REG_JUMP, jump);
		write_setting(REG_SCALE_X, scx);
		write_setting(REG_SCALE_Y, scy);
		write_setting(CFG_UNMAPPED_LO, 24'($urandom()));
		write_setting(CFG_UNMAPPED_HI, 24'($urandom()));
		cfg_write <= 1'b0;
	endtask

	task automatic send_item(input logic signed [31:0] sx, sy, dt, input bit typed,
			input motion_result_t typed_want);
		motion_result_t want;
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_x <= sx;
		sample_y <= sy;
		elapsed <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		want = advance_tracker(sx, sy, dt);
		expected_motion.push_back(typed ? typed_want : want);
	endtask

	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_motion.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		motion_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motion.size() == 0) begin
				log_fault("result transfer with no expectation pending");
			end else begin
				want = expected_motion.pop_front();
				if (offset_x !== want.off_x)
					log_fault($sformatf("offset_x expected %0d got %0d", want.off_x, offset_x));
				if (offset_y !== want.off_y)
					log_fault($sformatf("offset_y expected %0d got %0d", want.off_y, offset_y));
				if (predicted_x !== want.pos_x)
					log_fault($sformatf("predicted_x expected %h got %h", want.pos_x, predicted_x));
				if (predicted_y !== want.pos_y)
					log_fault($sformatf("predicted_y expected %h got %h", want.pos_y, predicted_y));
			end
		end
	end

	initial begin
		logic signed [31:0] sx, sy, dt;
		int pick;
		int delta_x, delta_y;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			send_item(motion_table[row].sx, motion_table[row].sy, motion_table[row].dt,
				motion_table[row].typed, motion_table[row].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			drain_results(SETTLE_CYCLES);
			case (phase)
				0: ;
				1: program_block(24'hFFFFFF, 24'h00FFFF, 24'h0000FF, 24'h0000FF,
					24'hFFFFFF, 24'hFFFFFF);
				2: program_block(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
				3: program_block(24'(GAIN_ONE), 24'(HOLD_RESET), 24'(VSCALE_RESET),
					24'(JUMP_RESET), SCALE_X_RESET, SCALE_Y_RESET);
				default: program_block({7'($urandom()), 17'($urandom_range(0, 'h1FFFF))},
					24'($urandom()), 24'($urandom()),
					{16'($urandom()), 8'($urandom_range(0, 6))},
					24'($urandom()), 24'($urandom()));
			endcase
			sender_gap_pct = gap_by_mode[phase % 4];
			recv_stall_pct = stall_by_mode[phase % 4];

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PAUSE_POINT) drain_results(0);
				pick = $urandom_range(99);
				if (pick < 12) begin
					sx = $urandom();
					sy = $urandom();
				end else if (pick < 40) begin
					sx = seen_x[31:0];
					sy = seen_y[31:0];
				end else begin
					delta_x = int'($urandom_range(0, 'h30000)) - 'sh18000;
					delta_y = int'($urandom_range(0, 'h30000)) - 'sh18000;
					sx = seen_x[31:0] + delta_x;
					sy = seen_y[31:0] + delta_y;
				end
				case ($urandom_range(9))
					0: dt = -int'($urandom_range(0, 'h2000));
					1: dt = $urandom();
					default: dt = $urandom_range(0, 'h1000);
				endcase
				send_item(sx, sy, dt, 1'b0, ZERO_RESULT);
			end
		end

		drain_results(SETTLE_CYCLES);
		if (fault_count == 0 && expected_motion.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/fpmp_pkg.sv
rtl/fpmp_mult.sv
rtl/fixed_point_motion_predictor.sv
sim/fixed_point_motion_predictor_tb.sv
